FILE: rtl/vertex_dedup_index_builder_top_assert.svh
// assertion macros shared by the rtl
`ifndef VERTEX_DEDUP_INDEX_BUILDER_TOP_ASSERT_SVH
`define VERTEX_DEDUP_INDEX_BUILDER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// a holds at an edge, so b holds at the same edge
`define VDDIB_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("implication check failed");
// a holds at an edge, so b holds at the following edge
`define VDDIB_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define VDDIB_ASSERT_IMP(label, clk, rst_n, a, b)
`define VDDIB_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

FILE: rtl/vddib_pkg.sv
package vddib_pkg;

    localparam int POSITION_DEPTH = 1024;
    localparam int VERTEX_DEPTH   = 1024;

    localparam int COORD_W = 32;
    localparam int VTX_W   = 3 * COORD_W;
    localparam int NUM_W   = 16;
    localparam int INDEX_W = 10;
    localparam int STATUS_W = 3;

    localparam int PADDR_W = $clog2(POSITION_DEPTH);
    localparam int PCNT_W  = $clog2(POSITION_DEPTH + 1);
    localparam int VADDR_W = $clog2(VERTEX_DEPTH);
    localparam int VCNT_W  = $clog2(VERTEX_DEPTH + 1);
    localparam int NUM_CMP_W = (PCNT_W > NUM_W) ? PCNT_W : NUM_W;

    localparam logic CMD_POSITION = 1'b0;
    localparam logic CMD_CORNER   = 1'b1;

    typedef logic [VTX_W-1:0] vertex_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_POS_STORED = 3'd0,
        ST_POS_FULL   = 3'd1,
        ST_MATCHED    = 3'd2,
        ST_ADDED      = 3'd3,
        ST_VTX_FULL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SEARCH,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic               en;
        logic [PADDR_W-1:0] addr;
        vertex_t            data;
    } pos_wr_t;

    typedef struct packed {
        logic               en;
        logic [PADDR_W-1:0] addr;
    } pos_rd_t;

    typedef struct packed {
        logic               en;
        logic [VADDR_W-1:0] addr;
        vertex_t            data;
    } vtx_wr_t;

    typedef struct packed {
        logic               en;
        logic [VADDR_W-1:0] addr;
    } vtx_rd_t;

endpackage

FILE: rtl/vertex_dedup_index_builder_top.sv
// vertex dedup index builder: takes parsed mesh requests one at a time and returns exactly
// one result per request. a position request (command 0) appends its x,y,z bit patterns to
// the position memory; a face-corner request (command 1) picks position number n (1-based,
// 0 or beyond the stored count picks the all-zero vertex), scans the unique-vertex memory
// from entry 0 for a bitwise match and returns its index, or appends the vertex and returns
// the new index. full memories drop the request and report it in status. a position request
// goes from idle through the emit state back to idle; a face corner reads its position
// (skipped when its number is out of range), then scans the vertex memory one entry per
// cycle through its single read port, stopping early on a match, and ends in the emit
// state. emit waits while the output register is full; a finished result sits in that
// register, so the next request is taken while it waits. both memories are undefined after
// reset and only entries below their fill counts are ever read, so there is no clearing pass

module vertex_dedup_index_builder_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [vddib_pkg::COORD_W-1:0]   s_coord_x,
    input  logic [vddib_pkg::COORD_W-1:0]   s_coord_y,
    input  logic [vddib_pkg::COORD_W-1:0]   s_coord_z,
    input  logic [vddib_pkg::NUM_W-1:0]     s_position_number,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [vddib_pkg::STATUS_W-1:0]  m_status,
    output logic [vddib_pkg::INDEX_W-1:0]   m_vertex_index
);

    // memory request buses between the sequencer and the two stores
    vddib_pkg::pos_wr_t pos_wr;
    vddib_pkg::pos_rd_t pos_rd;
    vddib_pkg::vtx_wr_t vtx_wr;
    vddib_pkg::vtx_rd_t vtx_rd;
    vddib_pkg::vertex_t pos_rd_data;
    vddib_pkg::vertex_t vtx_rd_data;

    // sequencer: request decode, vertex scan, append and output register
    vddib_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_coord_x         (s_coord_x),
        .s_coord_y         (s_coord_y),
        .s_coord_z         (s_coord_z),
        .s_position_number (s_position_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_vertex_index    (m_vertex_index),
        .pos_wr            (pos_wr),
        .pos_rd            (pos_rd),
        .pos_rd_data       (pos_rd_data),
        .vtx_wr            (vtx_wr),
        .vtx_rd            (vtx_rd),
        .vtx_rd_data       (vtx_rd_data)
    );

    // position memory, one entry per stored triple, x in the top word
    vddib_ram #(
        .DEPTH  (vddib_pkg::POSITION_DEPTH),
        .WIDTH  (vddib_pkg::VTX_W),
        .ADDR_W (vddib_pkg::PADDR_W)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_wr.en),
        .waddr (pos_wr.addr),
        .wdata (pos_wr.data),
        .re    (pos_rd.en),
        .raddr (pos_rd.addr),
        .rdata (pos_rd_data)
    );

    // unique-vertex memory, scanned in index order
    vddib_ram #(
        .DEPTH  (vddib_pkg::VERTEX_DEPTH),
        .WIDTH  (vddib_pkg::VTX_W),
        .ADDR_W (vddib_pkg::VADDR_W)
    ) u_vtx_ram (
        .aclk  (aclk),
        .we    (vtx_wr.en),
        .waddr (vtx_wr.addr),
        .wdata (vtx_wr.data),
        .re    (vtx_rd.en),
        .raddr (vtx_rd.addr),
        .rdata (vtx_rd_data)
    );

endmodule

FILE: rtl/vddib_ram.sv
module vddib_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 96,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/vddib_ctrl.sv
`include "vertex_dedup_index_builder_top_assert.svh"

module vddib_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [vddib_pkg::COORD_W-1:0]       s_coord_x,
    input  logic [vddib_pkg::COORD_W-1:0]       s_coord_y,
    input  logic [vddib_pkg::COORD_W-1:0]       s_coord_z,
    input  logic [vddib_pkg::NUM_W-1:0]         s_position_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vddib_pkg::STATUS_W-1:0]      m_status,
    output logic [vddib_pkg::INDEX_W-1:0]       m_vertex_index,
    output vddib_pkg::pos_wr_t                  pos_wr,
    output vddib_pkg::pos_rd_t                  pos_rd,
    input  vddib_pkg::vertex_t                  pos_rd_data,
    output vddib_pkg::vtx_wr_t                  vtx_wr,
    output vddib_pkg::vtx_rd_t                  vtx_rd,
    input  vddib_pkg::vertex_t                  vtx_rd_data
);

    vddib_pkg::ctrl_state_t state_reg, state_next;
    logic [vddib_pkg::PCNT_W-1:0]  pos_count_reg, pos_count_next;
    logic [vddib_pkg::VCNT_W-1:0]  vtx_count_reg, vtx_count_next;
    logic [vddib_pkg::VADDR_W-1:0] j_reg, j_next;
    vddib_pkg::vertex_t            key_reg, key_next;
    vddib_pkg::status_t            res_status_reg, res_status_next;
    logic [vddib_pkg::INDEX_W-1:0] res_index_reg, res_index_next;
    logic                          m_valid_reg, m_valid_next;
    vddib_pkg::status_t            m_status_reg, m_status_next;
    logic [vddib_pkg::INDEX_W-1:0] m_index_reg, m_index_next;

    logic [vddib_pkg::NUM_CMP_W-1:0] num_ext;
    logic [vddib_pkg::NUM_CMP_W-1:0] cnt_ext;
    logic [vddib_pkg::NUM_W-1:0]     num_m1;
    logic                            in_range;
    logic                            go_search;
    logic                            do_append;
    vddib_pkg::vertex_t              key_cur;
    vddib_pkg::vertex_t              append_key;

    assign num_ext  = vddib_pkg::NUM_CMP_W'(s_position_number);
    assign cnt_ext  = vddib_pkg::NUM_CMP_W'(pos_count_reg);
    assign num_m1   = s_position_number - vddib_pkg::NUM_W'(1);
    assign in_range = (s_position_number != '0) && (num_ext <= cnt_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vddib_pkg::S_IDLE;
            pos_count_reg <= '0;
            vtx_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_count_reg <= pos_count_next;
            vtx_count_reg <= vtx_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg          <= j_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
    end

    always_comb begin
        state_next      = state_reg;
        pos_count_next  = pos_count_reg;
        vtx_count_next  = vtx_count_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        pos_wr          = '0;
        pos_rd          = '0;
        vtx_wr          = '0;
        vtx_rd          = '0;
        s_ready         = 1'b0;
        go_search       = 1'b0;
        do_append       = 1'b0;
        key_cur         = '0;
        append_key      = key_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            vddib_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == vddib_pkg::CMD_POSITION) begin
                        res_index_next = '0;
                        state_next     = vddib_pkg::S_EMIT;
                        if (pos_count_reg >= vddib_pkg::PCNT_W'(vddib_pkg::POSITION_DEPTH))
                        begin
                            res_status_next = vddib_pkg::ST_POS_FULL;
                        end else begin
                            pos_wr.en       = 1'b1;
                            pos_wr.addr     = pos_count_reg[vddib_pkg::PADDR_W-1:0];
                            pos_wr.data     = {s_coord_x, s_coord_y, s_coord_z};
                            pos_count_next  = pos_count_reg + 1'b1;
                            res_status_next = vddib_pkg::ST_POS_STORED;
                        end
                    end else if (in_range) begin
                        pos_rd.en   = 1'b1;
                        pos_rd.addr = vddib_pkg::PADDR_W'(num_m1);
                        state_next  = vddib_pkg::S_FETCH;
                    end else begin
                        go_search = 1'b1;
                        key_cur   = '0;
                    end
                end
            end
            vddib_pkg::S_FETCH: begin
                go_search = 1'b1;
                key_cur   = pos_rd_data;
            end
            vddib_pkg::S_SEARCH: begin
                if (vtx_rd_data == key_reg) begin
                    res_status_next = vddib_pkg::ST_MATCHED;
                    res_index_next  = vddib_pkg::INDEX_W'(j_reg);
                    state_next      = vddib_pkg::S_EMIT;
                end else if ((vddib_pkg::VCNT_W'(j_reg) + 1'b1) < vtx_count_reg) begin
                    j_next      = j_reg + 1'b1;
                    vtx_rd.en   = 1'b1;
                    vtx_rd.addr = j_reg + 1'b1;
                end else begin
                    do_append = 1'b1;
                end
            end
            vddib_pkg::S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    state_next    = vddib_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = vddib_pkg::S_IDLE;
            end
        endcase

        // start of the scan, first entry read is issued here; an empty vertex memory appends at once
        if (go_search) begin
            key_next   = key_cur;
            append_key = key_cur;
            if (vtx_count_reg == '0) begin
                do_append = 1'b1;
            end else begin
                vtx_rd.en   = 1'b1;
                vtx_rd.addr = '0;
                j_next      = '0;
                state_next  = vddib_pkg::S_SEARCH;
            end
        end

        if (do_append) begin
            state_next = vddib_pkg::S_EMIT;
            if (vtx_count_reg >= vddib_pkg::VCNT_W'(vddib_pkg::VERTEX_DEPTH)) begin
                res_status_next = vddib_pkg::ST_VTX_FULL;
                res_index_next  = '0;
            end else begin
                vtx_wr.en       = 1'b1;
                vtx_wr.addr     = vtx_count_reg[vddib_pkg::VADDR_W-1:0];
                vtx_wr.data     = append_key;
                vtx_count_next  = vtx_count_reg + 1'b1;
                res_status_next = vddib_pkg::ST_ADDED;
                res_index_next  = vddib_pkg::INDEX_W'(vtx_count_reg);
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_vertex_index = m_index_reg;

    `VDDIB_ASSERT_IMP(a_pos_wr_room, aclk, aresetn, pos_wr.en, pos_count_reg < vddib_pkg::POSITION_DEPTH)
    `VDDIB_ASSERT_IMP(a_vtx_wr_room, aclk, aresetn, vtx_wr.en, vtx_count_reg < vddib_pkg::VERTEX_DEPTH)
    `VDDIB_ASSERT_NXT(a_vtx_grow, aclk, aresetn, vtx_wr.en, vtx_count_reg == $past(vtx_count_reg) + 1)
    `VDDIB_ASSERT_IMP(a_scan_bound, aclk, aresetn, state_reg == vddib_pkg::S_SEARCH, vddib_pkg::VCNT_W'(j_reg) < vtx_count_reg)

endmodule
